// File: hw/rtl/oal_pkg.sv
package oal_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int KIND_W      = 3;
    localparam int POS_W       = 7;
    localparam int VAL_W       = 32;
    localparam int STAT_W      = 2;
    localparam int CNT_OUT_W   = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [KIND_W-1:0] {
        K_APPEND = 3'd0,
        K_INSERT = 3'd1,
        K_DELETE = 3'd2,
        K_READ   = 3'd3,
        K_FIND   = 3'd4
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        W_INS  = 2'd0,
        W_DEL  = 2'd1,
        W_READ = 2'd2,
        W_FIND = 2'd3
    } t_walk;

    typedef struct packed {
        logic    load;
        logic    set_status;
        t_status status;
        logic    wr_val_end;
        logic    wr_val_pos;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    walk_start;
        t_walk   walk_mode;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              pos_bad;
        logic              ins_bad;
        logic              ins_at_end;
        logic              empty;
        logic              walk_done;
    } t_dp_stat;

endpackage

// File: hw/rtl/oal_datapath.sv
module oal_datapath
    import oal_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output t_dp_stat               o_stat,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [VAL_W-1:0]       r_mem [CAPACITY];
    logic [VAL_W-1:0]       r_rdata;
    logic [KIND_W-1:0]      r_kind;
    logic [POS_W-1:0]       r_pos;
    logic [VAL_W-1:0]       r_val;
    logic [CW-1:0]          r_count, n_count;
    logic [AW-1:0]          r_rp, n_rp;
    logic [AW-1:0]          r_last, n_last;
    logic [AW-1:0]          r_ra, n_ra;
    logic                   r_issue, n_issue;
    logic                   r_rv, n_rv;
    t_walk                  r_mode, n_mode;
    t_status                r_status, n_status;
    logic [VAL_W-1:0]       r_rd, n_rd;
    logic [POS_W-1:0]       r_fpos, n_fpos;
    logic [OUT_TDATA_W-1:0] r_out;
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [VAL_W-1:0]       wdata;
    logic [XW-1:0]          pos_x, cnt_x;
    logic [AW-1:0]          pos_a, cnt_a;
    logic                   hit;

    assign pos_x = XW'(r_pos);
    assign cnt_x = XW'(r_count);
    assign pos_a = AW'(pos_x - XW'(1));
    assign cnt_a = AW'(cnt_x - XW'(1));
    assign hit   = r_rv && (r_mode == W_FIND) && (r_rdata == r_val);

    assign o_stat.kind       = r_kind;
    assign o_stat.full       = (r_count == CW'(CAPACITY));
    assign o_stat.pos_bad    = (r_pos == '0) || (pos_x > cnt_x);
    assign o_stat.ins_bad    = (r_pos == '0) || (pos_x > cnt_x + XW'(1));
    assign o_stat.ins_at_end = (pos_x == cnt_x + XW'(1));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.walk_done  = !r_issue && !r_rv;

    assign o_m_tdata = r_out;

    always_comb begin
        n_count  = r_count;
        n_rp     = r_rp;
        n_last   = r_last;
        n_ra     = r_ra;
        n_issue  = r_issue;
        n_rv     = 1'b0;
        n_mode   = r_mode;
        n_status = r_status;
        n_rd     = r_rd;
        n_fpos   = r_fpos;
        we       = 1'b0;
        waddr    = r_ra;
        wdata    = r_rdata;

        if (i_cmd.load) begin
            n_status = ST_OK;
            n_rd     = '0;
            n_fpos   = '0;
        end
        if (i_cmd.set_status) begin
            n_status = i_cmd.status;
        end
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end
        if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end
        if (i_cmd.wr_val_end) begin
            we    = 1'b1;
            waddr = AW'(r_count);
            wdata = r_val;
        end
        if (i_cmd.wr_val_pos) begin
            we    = 1'b1;
            waddr = pos_a;
            wdata = r_val;
        end

        if (i_cmd.walk_start) begin
            n_mode  = i_cmd.walk_mode;
            n_issue = 1'b1;
            case (i_cmd.walk_mode)
                W_INS: begin
                    n_rp   = cnt_a;
                    n_last = pos_a;
                end
                W_DEL: begin
                    n_rp   = pos_a;
                    n_last = cnt_a;
                end
                W_READ: begin
                    n_rp   = pos_a;
                    n_last = pos_a;
                end
                default: begin
                    n_rp   = '0;
                    n_last = cnt_a;
                end
            endcase
        end

        if (r_issue) begin
            n_rv = 1'b1;
            n_ra = r_rp;
            if (r_rp == r_last) begin
                n_issue = 1'b0;
            end else if (r_mode == W_INS) begin
                n_rp = r_rp - AW'(1);
            end else begin
                n_rp = r_rp + AW'(1);
            end
        end

        if (r_rv) begin
            case (r_mode)
                W_INS: begin
                    we    = 1'b1;
                    waddr = r_ra + AW'(1);
                end
                W_DEL: begin
                    if (r_ra == pos_a) begin
                        n_rd = r_rdata;
                    end else begin
                        we    = 1'b1;
                        waddr = r_ra - AW'(1);
                    end
                end
                W_READ: begin
                    n_rd = r_rdata;
                end
                default: begin
                    if (hit) begin
                        n_status = ST_OK;
                        n_fpos   = POS_W'(XW'(r_ra) + XW'(1));
                        n_issue  = 1'b0;
                        n_rv     = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_issue <= 1'b0;
            r_rv    <= 1'b0;
        end else begin
            r_count <= n_count;
            r_issue <= n_issue;
            r_rv    <= n_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rp     <= n_rp;
        r_last   <= n_last;
        r_ra     <= n_ra;
        r_mode   <= n_mode;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_fpos   <= n_fpos;
        if (i_cmd.load) begin
            r_kind <= i_s_tdata[2:0];
            r_pos  <= i_s_tdata[9:3];
            r_val  <= i_s_tdata[41:10];
        end
        if (i_cmd.out_load) begin
            r_out <= {CNT_OUT_W'(r_count), r_fpos, r_rd, r_status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[r_rp];
    end

endmodule

// File: hw/rtl/oal_ctrl.sv
module oal_ctrl
    import oal_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_WALK   = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_m_tready;
        o_cmd    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_stat.kind)
                    K_APPEND: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else begin
                            o_cmd.wr_val_end = 1'b1;
                            o_cmd.cnt_inc    = 1'b1;
                        end
                    end
                    K_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else if (i_stat.ins_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                        end else if (i_stat.ins_at_end) begin
                            o_cmd.wr_val_pos = 1'b1;
                            o_cmd.cnt_inc    = 1'b1;
                        end else begin
                            o_cmd.walk_start = 1'b1;
                            o_cmd.walk_mode  = W_INS;
                            n_state          = S_WALK;
                        end
                    end
                    K_DELETE: begin
                        if (i_stat.pos_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                        end else begin
                            o_cmd.walk_start = 1'b1;
                            o_cmd.walk_mode  = W_DEL;
                            n_state          = S_WALK;
                        end
                    end
                    K_READ: begin
                        if (i_stat.pos_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                        end else begin
                            o_cmd.walk_start = 1'b1;
                            o_cmd.walk_mode  = W_READ;
                            n_state          = S_WALK;
                        end
                    end
                    K_FIND: begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NOTFOUND;
                        if (!i_stat.empty) begin
                            o_cmd.walk_start = 1'b1;
                            o_cmd.walk_mode  = W_FIND;
                            n_state          = S_WALK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    n_state = S_DONE;
                    if (i_stat.kind == K_INSERT) begin
                        o_cmd.wr_val_pos = 1'b1;
                        o_cmd.cnt_inc    = 1'b1;
                    end
                    if (i_stat.kind == K_DELETE) begin
                        o_cmd.cnt_dec = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// File: hw/rtl/ordered_array_list_engine.sv
// Append, insert at the end, find in an empty list, rejected requests and unused kinds pass
// from decode straight to the result register; other reads, inserts, deletes and finds
// first walk the entries they need, one per cycle (a find stops at its first match).
// A result that finds the previous beat still waiting holds until m_axis_tready; the next
// input beat is taken the cycle after it is loaded.
// Reset clears the entry count and the handshake state; entry memory is not cleared.
module ordered_array_list_engine
    import oal_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // kind[2:0], position[9:3], value[41:10], zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status[1:0], read_value[33:2], found_position[40:34], count[47:41]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    oal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    oal_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_s_tdata (s_axis_tdata),
        .o_stat    (stat),
        .o_m_tdata (m_axis_tdata)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input beat taken while a request is in progress");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == ST_FULL))
        |-> (m_axis_tdata[47:41] == CNT_OUT_W'(CAPACITY)))
        else $error("full status with a count below capacity");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[40:34] != '0)) |-> (m_axis_tdata[1:0] == ST_OK))
        else $error("found position reported with a failing status");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten while its beat waits");

endmodule
